>>> rtl/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg: shared definitions for the chained hash index
// Field widths, default sizes, request codes, controller states and the
// write-enable group that passes between the controller and the tables.
// ----------------------------------------------------------------------------
package chi_pkg;

  // Default sizes (all powers of two)
  localparam int MAX_NODES_DEF       = 1024;
  localparam int MAX_BUCKETS_DEF     = 2048;
  localparam int INITIAL_BUCKETS_DEF = 64;

  // Fixed field widths of the request and result channels
  localparam int REQ_W    = 2;
  localparam int NODE_IDX_W = 10;
  localparam int HASH_W   = 64;
  localparam int COUNT_W  = 11;

  // Width used for mixed-width compares
  localparam int CMP_W = 32;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIRST  = 2'd1,
    REQ_NEXT   = 2'd2,
    REQ_RESET  = 2'd3
  } chi_req_t;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_EXT   = 8'b0000_0100,
    S_CLEAR = 8'b0000_1000,
    S_RB_RD = 8'b0001_0000,
    S_RB_HD = 8'b0010_0000,
    S_RB_WR = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } chi_state_t;

  // Write enables of the table memories
  typedef struct packed {
    logic head_we;
    logic link_we;
    logic bits_we;
  } chi_we_t;

endpackage

>>> rtl/chi_tables.sv
// ----------------------------------------------------------------------------
// chi_tables: bucket head memory and node memory
// Two synchronous memories with registered reads. The node memory holds a
// chain link and the stored bucket bits per node, each field with its own
// write enable.
// ----------------------------------------------------------------------------
module chi_tables
  import chi_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  localparam int NODE_W     = $clog2(MAX_NODES),
  localparam int HEAD_W     = $clog2(MAX_NODES + 1),
  localparam int BK_W       = $clog2(MAX_BUCKETS)
) (
  input  logic              clk,
  input  chi_we_t           we,
  input  logic [BK_W-1:0]   head_raddr,
  input  logic [BK_W-1:0]   head_waddr,
  input  logic [HEAD_W-1:0] head_wdata,
  output logic [HEAD_W-1:0] head_rdata,
  input  logic [NODE_W-1:0] node_raddr,
  input  logic [NODE_W-1:0] node_waddr,
  input  logic [HEAD_W-1:0] link_wdata,
  input  logic [BK_W-1:0]   bits_wdata,
  output logic [HEAD_W-1:0] link_rdata,
  output logic [BK_W-1:0]   bits_rdata
);

  localparam int NW = HEAD_W + BK_W;

  logic [HEAD_W-1:0] head_mem [MAX_BUCKETS];
  logic [NW-1:0]     node_mem [MAX_NODES];
  logic [NW-1:0]     node_q;

  // Bucket heads: one write, one registered read
  always_ff @(posedge clk) begin
    if (we.head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata <= head_mem[head_raddr];
  end

  // Node entries: link and bucket bits written separately
  always_ff @(posedge clk) begin
    if (we.link_we) begin
      node_mem[node_waddr][NW-1:BK_W] <= link_wdata;
    end
    if (we.bits_we) begin
      node_mem[node_waddr][BK_W-1:0] <= bits_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  assign link_rdata = node_q[NW-1:BK_W];
  assign bits_rdata = node_q[BK_W-1:0];

endmodule

>>> rtl/chained_hash_index.sv
// ----------------------------------------------------------------------------
// chained_hash_index: hash index over node numbers with separate chaining
// Bucket heads and per-node links live in synchronous memories; a small
// controller reads, modifies and writes them back, and walks them to clear
// the buckets and to rechain the nodes in use when the bucket count doubles.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | in        | in_valid/in_stall  | req_type, node_index, hash_key,
//           |           |                    | type_count
//  out_     | out       | out_valid/out_stall| ok, node_out, grew
//
//  For lookups and plain inserts the accept edge reads both memories, and
//  S_EXEC writes back; the result register is loaded when it is free.
//  An insert past the link length then gives empty links to the skipped
//  nodes in S_EXT. A growing insert clears the heads of the doubled bucket
//  count in S_CLEAR, reads the first node in S_RB_RD and rechains each node
//  in use through S_RB_HD and S_RB_WR. A reset request clears the heads below
//  the bucket count. Each ends with the result load in S_RESP. After rst_n the
//  initial heads are cleared before any request. in_stall is low only when idle;
//  the result register holds one result while out_stall is high.
//  All three size parameters must be powers of two.
// ----------------------------------------------------------------------------
module chained_hash_index
  import chi_pkg::*;
#(
  parameter int MAX_NODES       = MAX_NODES_DEF,
  parameter int MAX_BUCKETS     = MAX_BUCKETS_DEF,
  parameter int INITIAL_BUCKETS = INITIAL_BUCKETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [NODE_IDX_W-1:0] in_node_index,
  input  logic [HASH_W-1:0]     in_hash_key,
  input  logic [COUNT_W-1:0]    in_type_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ok,
  output logic [NODE_IDX_W-1:0] out_node_out,
  output logic                  out_grew
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int HEAD_W = $clog2(MAX_NODES + 1);
  localparam int BK_W   = $clog2(MAX_BUCKETS);
  localparam int BC_W   = $clog2(MAX_BUCKETS + 1);
  localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(MAX_NODES);

  // Control registers
  chi_state_t        state_r, state_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [HEAD_W-1:0] ll_r, ll_nxt;
  logic [BK_W-1:0]   clr_r, clr_nxt;
  logic              rb_r, rb_nxt;
  logic              resp_r, resp_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Request and work registers
  chi_req_t            req_r;
  logic [NODE_IDX_W-1:0] node_raw_r;
  logic [NODE_W-1:0]   node_r;
  logic [BK_W-1:0]     hb_r;
  logic [COUNT_W-1:0]  count_r;
  logic [BK_W-1:0]     b_r, b_nxt;
  logic [NODE_W-1:0]   ext_r, ext_nxt;
  logic [NODE_W-1:0]   n_r, n_nxt;
  logic [HEAD_W-1:0]   limit_r, limit_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [NODE_IDX_W-1:0] res_node_r, res_node_nxt;
  logic                res_grew_r, res_grew_nxt;
  logic                out_ok_r;
  logic [NODE_IDX_W-1:0] out_node_r;
  logic                out_grew_r;

  // Memory interface
  chi_we_t           we;
  logic [BK_W-1:0]   head_raddr, head_waddr;
  logic [HEAD_W-1:0] head_wdata, head_rdata;
  logic [NODE_W-1:0] node_raddr, node_waddr;
  logic [HEAD_W-1:0] link_wdata, link_rdata;
  logic [BK_W-1:0]   bits_wdata, bits_rdata;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [BK_W-1:0]   bk_mask;
  logic              node_ok;
  logic              grow;
  logic [HEAD_W-1:0] ll_new;
  logic [CMP_W-1:0]  bc_dbl;

  chi_tables #(
    .MAX_NODES   (MAX_NODES),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_tables (
    .clk        (clk),
    .we         (we),
    .head_raddr (head_raddr),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .node_raddr (node_raddr),
    .node_waddr (node_waddr),
    .link_wdata (link_wdata),
    .bits_wdata (bits_wdata),
    .link_rdata (link_rdata),
    .bits_rdata (bits_rdata)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && (state_r == S_IDLE);
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_node_out = out_node_r;
  assign out_grew     = out_grew_r;
  assign bk_mask      = BK_W'(bc_r - BC_W'(1));

  // Insert checks and growth decision
  always_comb begin
    node_ok = (CMP_W'(node_raw_r) < CMP_W'(count_r)) &&
              (CMP_W'(node_raw_r) < CMP_W'(MAX_NODES));
    grow    = (CMP_W'(count_r) > (CMP_W'(bc_r) - CMP_W'(bc_r >> 2))) &&
              (CMP_W'(bc_r) < CMP_W'(MAX_BUCKETS));
    ll_new  = (CMP_W'(node_r) + CMP_W'(1) > CMP_W'(ll_r)) ?
              HEAD_W'(node_r) + HEAD_W'(1) : ll_r;
    bc_dbl  = CMP_W'(bc_r) << 1;
  end

  // Controller
  always_comb begin
    state_nxt    = state_r;
    bc_nxt       = bc_r;
    ll_nxt       = ll_r;
    clr_nxt      = clr_r;
    rb_nxt       = rb_r;
    resp_nxt     = resp_r;
    b_nxt        = b_r;
    ext_nxt      = ext_r;
    n_nxt        = n_r;
    limit_nxt    = limit_r;
    res_ok_nxt   = res_ok_r;
    res_node_nxt = res_node_r;
    res_grew_nxt = res_grew_r;
    out_load     = 1'b0;
    we           = '0;
    head_raddr   = BK_W'(in_hash_key) & bk_mask;
    head_waddr   = b_r;
    head_wdata   = HEAD_W'(node_r);
    node_raddr   = NODE_W'(in_node_index);
    node_waddr   = node_r;
    link_wdata   = head_rdata;
    bits_wdata   = hb_r;

    case (state_r)
      S_IDLE: begin
        // read both tables at the accept edge
        if (accept) begin
          b_nxt     = head_raddr;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_ok_nxt   = 1'b0;
        res_node_nxt = '0;
        res_grew_nxt = 1'b0;
        rb_nxt       = 1'b0;
        resp_nxt     = 1'b0;
        state_nxt    = S_RESP;
        case (req_r)
          REQ_INSERT: begin
            if (node_ok) begin
              res_ok_nxt = 1'b1;
              ll_nxt     = ll_new;
              we.bits_we = 1'b1;
              ext_nxt    = NODE_W'(ll_r);
              if (grow) begin
                // keep bucket bits only; all chains get rebuilt
                res_grew_nxt = 1'b1;
                rb_nxt       = 1'b1;
                bc_nxt       = (bc_dbl > CMP_W'(MAX_BUCKETS)) ?
                               BC_W'(MAX_BUCKETS) : BC_W'(bc_dbl);
                limit_nxt    = (CMP_W'(count_r) < CMP_W'(ll_new)) ?
                               HEAD_W'(count_r) : ll_new;
                clr_nxt      = '0;
                state_nxt    = S_CLEAR;
              end else begin
                // push onto the bucket chain
                we.link_we = 1'b1;
                we.head_we = 1'b1;
              end
              if (CMP_W'(node_r) > CMP_W'(ll_r)) begin
                state_nxt = S_EXT;
              end
            end
          end
          REQ_FIRST: begin
            if (head_rdata != EMPTY) begin
              res_ok_nxt   = 1'b1;
              res_node_nxt = NODE_IDX_W'(head_rdata);
            end
          end
          REQ_NEXT: begin
            if ((CMP_W'(node_raw_r) < CMP_W'(ll_r)) && (link_rdata != EMPTY)) begin
              res_ok_nxt   = 1'b1;
              res_node_nxt = NODE_IDX_W'(link_rdata);
            end
          end
          REQ_RESET: begin
            res_ok_nxt = 1'b1;
            ll_nxt     = '0;
            resp_nxt   = 1'b1;
            clr_nxt    = '0;
            state_nxt  = S_CLEAR;
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
        // deliver at once when nothing else is left to do
        if (state_nxt == S_RESP && out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_EXT: begin
        // give empty links to nodes skipped by this insert
        we.link_we = 1'b1;
        node_waddr = ext_r;
        link_wdata = EMPTY;
        ext_nxt    = ext_r + NODE_W'(1);
        if (ext_r + NODE_W'(1) == node_r) begin
          clr_nxt   = '0;
          state_nxt = rb_r ? S_CLEAR : S_RESP;
        end
      end

      S_CLEAR: begin
        // empty buckets below the bucket count
        we.head_we = 1'b1;
        head_waddr = clr_r;
        head_wdata = EMPTY;
        clr_nxt    = clr_r + BK_W'(1);
        if (clr_r == bk_mask) begin
          if (rb_r) begin
            n_nxt     = '0;
            state_nxt = S_RB_RD;
          end else if (resp_r) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RB_RD: begin
        node_raddr = n_r;
        state_nxt  = S_RB_HD;
      end

      S_RB_HD: begin
        // fetch the head of the node's new bucket
        head_raddr = bits_rdata & bk_mask;
        b_nxt      = bits_rdata & bk_mask;
        state_nxt  = S_RB_WR;
      end

      S_RB_WR: begin
        // chain the node in front of the current head
        we.link_we = 1'b1;
        we.head_we = 1'b1;
        node_waddr = n_r;
        head_wdata = HEAD_W'(n_r);
        node_raddr = n_r + NODE_W'(1);
        if (HEAD_W'(n_r) + HEAD_W'(1) == limit_r) begin
          state_nxt = S_RESP;
        end else begin
          n_nxt     = n_r + NODE_W'(1);
          state_nxt = S_RB_HD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // Control state; reset starts a clear of the initial buckets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bc_r        <= BC_W'(INITIAL_BUCKETS);
      ll_r        <= '0;
      clr_r       <= '0;
      rb_r        <= 1'b0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bc_r        <= bc_nxt;
      ll_r        <= ll_nxt;
      clr_r       <= clr_nxt;
      rb_r        <= rb_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture, work counters and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= chi_req_t'(in_req_type);
      node_raw_r <= in_node_index;
      node_r     <= NODE_W'(in_node_index);
      hb_r       <= BK_W'(in_hash_key);
      count_r    <= in_type_count;
    end
    b_r        <= b_nxt;
    ext_r      <= ext_nxt;
    n_r        <= n_nxt;
    limit_r    <= limit_nxt;
    res_ok_r   <= res_ok_nxt;
    res_node_r <= res_node_nxt;
    res_grew_r <= res_grew_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_nxt;
      out_node_r <= res_node_nxt;
      out_grew_r <= res_grew_nxt;
    end
  end

endmodule
